// File: src/ckl_pkg.sv
// ----------------------------------------------------------------------------
// ckl_pkg
// Shared types and constants for the compacting keyed list: request and
// status codes, word layouts and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
package ckl_pkg;

    localparam int CAPACITY_DEF     = 16;
    localparam int PAYLOAD_BITS_DEF = 32;

    localparam int CMD_W     = 2;
    localparam int KEY_W     = 16;
    localparam int PAYLOAD_W = 32;
    localparam int POS_W     = 8;
    localparam int STATUS_W  = 2;
    localparam int FPOS_W    = 4;
    localparam int COUNT_W   = 5;

    // slave word: key, payload, position
    localparam int IN_KEY_LSB = 0;
    localparam int IN_PAY_LSB = IN_KEY_LSB + KEY_W;
    localparam int IN_POS_LSB = IN_PAY_LSB + PAYLOAD_W;
    localparam int S_TDATA_W  = 56;

    // master word: found_position, out_key, out_payload, entry_count, is_empty
    localparam int OUT_FPOS_LSB  = 0;
    localparam int OUT_KEY_LSB   = OUT_FPOS_LSB + FPOS_W;
    localparam int OUT_PAY_LSB   = OUT_KEY_LSB + KEY_W;
    localparam int OUT_CNT_LSB   = OUT_PAY_LSB + PAYLOAD_W;
    localparam int OUT_EMPTY_BIT = OUT_CNT_LSB + COUNT_W;
    localparam int M_TDATA_W     = 64;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FIND   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd3;

    typedef struct packed {
        logic                accept;
        logic                insert;
        logic                fail;
        logic [STATUS_W-1:0] fail_code;
        logic                scan_init;
        logic                walk_step;
        logic                shift_init;
        logic                shift_write;
        logic                count_dec;
        logic                read_pos;
        logic                capture;
        logic                cap_pos;
        logic                publish;
    } ckl_ctrl_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             full;
        logic             in_range;
        logic             hit;
        logic             walk_done;
        logic             out_free;
    } ckl_stat_t;

endpackage

// File: src/ckl_ram.sv
// ----------------------------------------------------------------------------
// ckl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ckl_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: src/ckl_datapath.sv
// ----------------------------------------------------------------------------
// ckl_datapath
// Request registers, record count, walk indexes, entry RAM, result and
// output registers of the compacting keyed list.
// ----------------------------------------------------------------------------
module ckl_datapath #(
    parameter int CAPACITY     = 16,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ckl_pkg::ckl_ctrl_t           ctrl,
    output ckl_pkg::ckl_stat_t           stat,
    input  logic [ckl_pkg::CMD_W-1:0]    s_tuser,
    input  logic [ckl_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [ckl_pkg::STATUS_W-1:0] m_tuser,
    output logic [ckl_pkg::M_TDATA_W-1:0] m_tdata
);

    import ckl_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int ENT_W = KEY_W + PAYLOAD_BITS;
    localparam int PX_W  = PAYLOAD_BITS + PAYLOAD_W;
    localparam int FX_W  = IDX_W + FPOS_W;
    localparam int CX_W  = CNT_W + COUNT_W;
    localparam int PC_W  = POS_W + CNT_W;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    logic [CMD_W-1:0]        req_cmd_reg;
    logic [KEY_W-1:0]        req_key_reg;
    logic [PAYLOAD_BITS-1:0] req_pay_reg;
    logic [POS_W-1:0]        req_pos_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        rd_idx_reg;
    logic                    chk_valid_reg;
    logic [IDX_W-1:0]        chk_idx_reg;
    logic [IDX_W-1:0]        wr_idx_reg;
    logic [STATUS_W-1:0]     res_status_reg;
    logic [IDX_W-1:0]        res_fpos_reg;
    logic [KEY_W-1:0]        res_key_reg;
    logic [PAYLOAD_BITS-1:0] res_pay_reg;
    logic                    m_tvalid_reg;
    logic [STATUS_W-1:0]     m_tuser_reg;
    logic [M_TDATA_W-1:0]    m_tdata_reg;

    logic [PX_W-1:0]         in_pay_ext;
    logic [PX_W-1:0]         out_pay_ext;
    logic [FX_W-1:0]         fpos_ext;
    logic [CX_W-1:0]         cnt_ext;
    logic [PC_W-1:0]         pos_cmp;
    logic [PC_W-1:0]         cnt_cmp;
    logic                    rd_more;
    logic [IDX_W-1:0]        pos_idx;
    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    logic [ENT_W-1:0]        ram_wdata;
    logic [IDX_W-1:0]        ram_raddr;
    logic [ENT_W-1:0]        ram_rdata;
    logic [KEY_W-1:0]        rd_key;
    logic [PAYLOAD_BITS-1:0] rd_pay;

    assign in_pay_ext  = {{PAYLOAD_BITS{1'b0}}, s_tdata[IN_PAY_LSB +: PAYLOAD_W]};
    assign out_pay_ext = {{PAYLOAD_W{1'b0}}, res_pay_reg};
    assign fpos_ext    = {{FPOS_W{1'b0}}, res_fpos_reg};
    assign cnt_ext     = {{COUNT_W{1'b0}}, count_reg};
    assign pos_cmp     = {{CNT_W{1'b0}}, req_pos_reg};
    assign cnt_cmp     = {{POS_W{1'b0}}, count_reg};
    assign rd_more     = rd_idx_reg < count_reg;
    assign pos_idx     = req_pos_reg[IDX_W-1:0];
    assign rd_key      = ram_rdata[ENT_W-1 -: KEY_W];
    assign rd_pay      = ram_rdata[PAYLOAD_BITS-1:0];

    assign stat.cmd       = req_cmd_reg;
    assign stat.full      = count_reg >= CAP_CNT;
    assign stat.in_range  = pos_cmp < cnt_cmp;
    assign stat.hit       = chk_valid_reg && (rd_key == req_key_reg);
    assign stat.walk_done = !rd_more && !chk_valid_reg;
    assign stat.out_free  = !m_tvalid_reg || m_tready;

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = wr_idx_reg;
        ram_wdata = ram_rdata;
        if (ctrl.insert)
        begin
            ram_we    = 1'b1;
            ram_waddr = count_reg[IDX_W-1:0];
            ram_wdata = {req_key_reg, req_pay_reg};
        end
        else if (ctrl.shift_write && chk_valid_reg)
        begin
            ram_we = 1'b1;
        end
    end

    assign ram_raddr = ctrl.read_pos ? pos_idx : rd_idx_reg[IDX_W-1:0];

    ckl_ram #(
        .WIDTH (ENT_W),
        .DEPTH (CAPACITY)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            req_cmd_reg <= s_tuser;
            req_key_reg <= s_tdata[IN_KEY_LSB +: KEY_W];
            req_pay_reg <= in_pay_ext[PAYLOAD_BITS-1:0];
            req_pos_reg <= s_tdata[IN_POS_LSB +: POS_W];
        end
        if (ctrl.insert)
        begin
            res_status_reg <= ST_OK;
            res_fpos_reg   <= count_reg[IDX_W-1:0];
            res_key_reg    <= req_key_reg;
            res_pay_reg    <= req_pay_reg;
        end
        else if (ctrl.fail)
        begin
            res_status_reg <= ctrl.fail_code;
            res_fpos_reg   <= '0;
            res_key_reg    <= '0;
            res_pay_reg    <= '0;
        end
        else if (ctrl.capture)
        begin
            res_status_reg <= ST_OK;
            res_fpos_reg   <= ctrl.cap_pos ? pos_idx : chk_idx_reg;
            res_key_reg    <= rd_key;
            res_pay_reg    <= rd_pay;
        end
        if (ctrl.walk_step && rd_more)
        begin
            chk_idx_reg <= rd_idx_reg[IDX_W-1:0];
        end
        if (ctrl.shift_init)
        begin
            wr_idx_reg <= chk_idx_reg;
        end
        else if (ctrl.shift_write && chk_valid_reg)
        begin
            wr_idx_reg <= wr_idx_reg + 1'b1;
        end
        if (ctrl.publish)
        begin
            m_tuser_reg <= res_status_reg;
            m_tdata_reg <= {
                {(M_TDATA_W - OUT_EMPTY_BIT - 1){1'b0}},
                (count_reg == '0),
                cnt_ext[COUNT_W-1:0],
                out_pay_ext[PAYLOAD_W-1:0],
                res_key_reg,
                fpos_ext[FPOS_W-1:0]
            };
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            chk_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            if (ctrl.insert)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (ctrl.count_dec)
            begin
                count_reg <= count_reg - 1'b1;
            end

            if (ctrl.scan_init)
            begin
                rd_idx_reg    <= '0;
                chk_valid_reg <= 1'b0;
            end
            else if (ctrl.shift_init)
            begin
                rd_idx_reg    <= {{(CNT_W - IDX_W){1'b0}}, chk_idx_reg} + 1'b1;
                chk_valid_reg <= 1'b0;
            end
            else if (ctrl.walk_step)
            begin
                chk_valid_reg <= rd_more;
                if (rd_more)
                begin
                    rd_idx_reg <= rd_idx_reg + 1'b1;
                end
            end

            if (ctrl.publish)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// File: src/ckl_controller.sv
// ----------------------------------------------------------------------------
// ckl_controller
// Request sequencer of the compacting keyed list: dispatch, key scan,
// compaction shift, indexed read and result hand-off.
// ----------------------------------------------------------------------------
module ckl_controller (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  ckl_pkg::ckl_stat_t stat,
    output ckl_pkg::ckl_ctrl_t ctrl
);

    import ckl_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_SHIFT,
        S_RDWAIT,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    ctrl.accept = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (stat.cmd)
                    CMD_INSERT:
                    begin
                        if (stat.full)
                        begin
                            ctrl.fail      = 1'b1;
                            ctrl.fail_code = ST_FULL;
                        end
                        else
                        begin
                            ctrl.insert = 1'b1;
                        end
                        state_next = S_FINISH;
                    end
                    CMD_DELETE, CMD_FIND:
                    begin
                        ctrl.scan_init = 1'b1;
                        state_next     = S_SCAN;
                    end
                    CMD_READ:
                    begin
                        if (stat.in_range)
                        begin
                            ctrl.read_pos = 1'b1;
                            state_next    = S_RDWAIT;
                        end
                        else
                        begin
                            ctrl.fail      = 1'b1;
                            ctrl.fail_code = ST_RANGE;
                            state_next     = S_FINISH;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_SCAN:
            begin
                if (stat.hit)
                begin
                    ctrl.capture = 1'b1;
                    if (stat.cmd == CMD_DELETE)
                    begin
                        ctrl.shift_init = 1'b1;
                        state_next      = S_SHIFT;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
                else if (stat.walk_done)
                begin
                    ctrl.fail      = 1'b1;
                    ctrl.fail_code = ST_NOT_FOUND;
                    state_next     = S_FINISH;
                end
                else
                begin
                    ctrl.walk_step = 1'b1;
                end
            end
            S_SHIFT:
            begin
                if (stat.walk_done)
                begin
                    ctrl.count_dec = 1'b1;
                    state_next     = S_FINISH;
                end
                else
                begin
                    ctrl.walk_step   = 1'b1;
                    ctrl.shift_write = 1'b1;
                end
            end
            S_RDWAIT:
            begin
                ctrl.capture = 1'b1;
                ctrl.cap_pos = 1'b1;
                state_next   = S_FINISH;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    ctrl.publish = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

endmodule

// File: src/compacting_keyed_list.sv
// ----------------------------------------------------------------------------
// compacting_keyed_list
// Ordered table of keyed records with insert, delete by key (compacting),
// find by key and read by index.
//
//   channel  | dir | tuser                 | tdata (lowest bit up)
//   ---------+-----+-----------------------+---------------------------------
//   s_*      | in  | cmd                   | key, payload, position
//   m_*      | out | status                | found_position, out_key,
//            |     |                       | out_payload, entry_count, is_empty
//
// Insert, insert into a full list and out-of-range read go from dispatch
// straight to the result, an in-range read first waits on the RAM read, find
// scans by key and delete scans, then compacts: the scan and the compaction
// each move one entry per cycle through the entry RAM read port.
// One request is in flight at a time; the next is taken once the result sits
// in the output register, even while that word is still stalled.
// Reset clears the count, the controller state and the output valid; the
// entry RAM needs no clearing.
// ----------------------------------------------------------------------------
module compacting_keyed_list #(
    parameter int CAPACITY     = ckl_pkg::CAPACITY_DEF,
    parameter int PAYLOAD_BITS = ckl_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ckl_pkg::CMD_W-1:0]     s_tuser,  // cmd
    input  logic [ckl_pkg::S_TDATA_W-1:0] s_tdata,  // key, payload, position
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ckl_pkg::STATUS_W-1:0]  m_tuser,  // status
    output logic [ckl_pkg::M_TDATA_W-1:0] m_tdata   // found_position, out_key,
                                                    // out_payload, entry_count,
                                                    // is_empty, zero pad
);

    import ckl_pkg::*;

    ckl_ctrl_t ctrl;
    ckl_stat_t stat;

    ckl_controller u_controller (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    ckl_datapath #(
        .CAPACITY     (CAPACITY),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .stat     (stat),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata)
    );

endmodule

// File: src/ckl_checker.sv
// ----------------------------------------------------------------------------
// ckl_checker
// Port-level checks on the compacting keyed list, bound to the top level.
// ----------------------------------------------------------------------------
module ckl_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [ckl_pkg::CMD_W-1:0]     s_tuser,
    input logic [ckl_pkg::S_TDATA_W-1:0] s_tdata,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [ckl_pkg::STATUS_W-1:0]  m_tuser,
    input logic [ckl_pkg::M_TDATA_W-1:0] m_tdata
);

    import ckl_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[OUT_EMPTY_BIT] ==
                     (m_tdata[OUT_CNT_LSB +: COUNT_W] == '0))
        else $error("empty flag disagrees with count");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != ST_OK) |-> (m_tdata[OUT_CNT_LSB-1:0] == '0))
        else $error("rejected request carries entry fields");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while one is in flight");

endmodule

bind compacting_keyed_list ckl_checker u_ckl_checker (.*);
